@@ rtl/hvt_pkg.sv @@
// Shared widths, types and helpers of the homogeneous vertex transform.
package hvt_pkg;

	localparam int CW    = 32;           // coordinate width used from each input field
	localparam int MTW   = 32;           // matrix entry width
	localparam int PW    = MTW + CW;     // one product
	localparam int SW    = PW + 2;       // sum of four products
	localparam int NW    = SW - 16;      // row result after floor to 16 fraction bits (Q34.16)
	localparam int QW    = CW + 2;       // quotient bits, wider than the result so overflow can be seen
	localparam int QBW   = $clog2(QW);
	localparam int RW    = NW + CW + 2;  // divider partial remainder
	localparam int NREG  = 8;
	localparam int IDXW  = 4;
	localparam int CFGW  = 64;
	localparam int FW    = 32;           // field width at the ports

	localparam logic [CFGW-1:0] CFG_RESET [NREG] = '{
		64'h0001_0000_0000_0000, 64'h0,
		64'h0000_0000_0001_0000, 64'h0,
		64'h0,                   64'h0001_0000_0000_0000,
		64'h0,                   64'h0000_0000_0001_0000
	};

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SAT   = 2'd1,
		ST_WZERO = 2'd2
	} status_t;

	// One request through the divider: three lanes sharing one divisor.
	typedef struct packed {
		logic [NW-1:0]          d;
		logic [2:0][RW-1:0]     r;
		logic [2:0][QW-1:0]     q;
		logic [2:0]             neg;
		logic [2:0]             num_neg;
		logic [2:0]             num_nz;
		logic                   w_zero;
		logic                   tag;
	} div_t;

	// One restoring step at quotient bit b.
	function automatic div_t div_step(input div_t x, input logic [QBW-1:0] b);
		div_t y;
		logic [RW-1:0] dsh;
		y   = x;
		dsh = RW'(x.d) << b;
		for (int l = 0; l < 3; l++) begin
			if (x.r[l] >= dsh) begin
				y.r[l]    = x.r[l] - dsh;
				y.q[l][b] = 1'b1;
			end
		end
		return y;
	endfunction

endpackage

@@ rtl/hvt_if.sv @@
// Request channels of the vertex transform: vertex in, vertex out, register write.
interface hvt_vin_if;
	logic                     valid;
	logic                     ready;
	logic signed [hvt_pkg::FW-1:0] in_x;
	logic signed [hvt_pkg::FW-1:0] in_y;
	logic signed [hvt_pkg::FW-1:0] in_z;
	logic                     world_copy;
	modport source (output valid, in_x, in_y, in_z, world_copy, input ready);
	modport sink   (input valid, in_x, in_y, in_z, world_copy, output ready);
endinterface

interface hvt_vout_if;
	logic                     valid;
	logic                     ready;
	logic signed [hvt_pkg::FW-1:0] out_x;
	logic signed [hvt_pkg::FW-1:0] out_y;
	logic signed [hvt_pkg::FW-1:0] out_z;
	logic                     world_copy_out;
	logic [1:0]               status;
	modport source (output valid, out_x, out_y, out_z, world_copy_out, status, input ready);
	modport sink   (input valid, out_x, out_y, out_z, world_copy_out, status, output ready);
endinterface

interface hvt_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [hvt_pkg::IDXW-1:0]    index;
	logic [hvt_pkg::CFGW-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/homogeneous_vertex_transform.sv @@
// Top level of the homogeneous 4x4 vertex transform with perspective divide.
//
// Accepts one vertex per cycle while the output side keeps up and returns one
// projected vertex per vertex, in order, through 3 stages of multiply, row sum
// and divider setup, 34 divider stages and one output register.
// The depth is set by the restoring divider, which resolves one quotient bit
// per stage for x, y and z side by side. Every stage has its own valid bit and
// holds under backpressure, so bubbles close up and the input stays ready while
// a finished result waits if a stage ahead is empty. Matrix registers are
// written through the cfg channel (always ready; indexes past the last
// register are dropped) and must only be changed while no vertex is in flight.
module homogeneous_vertex_transform (
	input  logic       clk,
	input  logic       arst_n,
	hvt_vin_if.sink    vin,
	hvt_vout_if.source vout,
	hvt_cfg_if.sink    cfg
);

	localparam int CW = hvt_pkg::CW;
	localparam int PW = hvt_pkg::PW;
	localparam int SW = hvt_pkg::SW;
	localparam int NW = hvt_pkg::NW;
	localparam int QW = hvt_pkg::QW;
	localparam int RW = hvt_pkg::RW;

	// ---------------- matrix registers
	logic [hvt_pkg::CFGW-1:0] cfg_q [hvt_pkg::NREG];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hvt_pkg::NREG; i++) cfg_q[i] <= hvt_pkg::CFG_RESET[i];
		end else if (cfg.valid && cfg.ready && (cfg.index < hvt_pkg::IDXW'(hvt_pkg::NREG))) begin
			cfg_q[cfg.index[$clog2(hvt_pkg::NREG)-1:0]] <= cfg.data;
		end
	end

	// Row r: even register holds columns 0/1, odd register columns 2/3, upper half first.
	logic signed [hvt_pkg::MTW-1:0] mat [4][4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mat[r][0] = cfg_q[2*r][63:32];
			mat[r][1] = cfg_q[2*r][31:0];
			mat[r][2] = cfg_q[2*r+1][63:32];
			mat[r][3] = cfg_q[2*r+1][31:0];
		end
	end

	// ---------------- handshake chain
	logic adv1, adv2, adv3, div_in_ready;
	logic valid_s1, valid_s2, valid_s3;

	assign adv3      = !valid_s3 || div_in_ready;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign vin.ready = adv1;

	// ---------------- stage 1: sixteen products
	logic signed [CW-1:0] vext [3];
	assign vext[0] = vin.in_x[CW-1:0];
	assign vext[1] = vin.in_y[CW-1:0];
	assign vext[2] = vin.in_z[CW-1:0];

	logic signed [PW-1:0] prod_s1 [4][4];
	logic                 tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= vin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			tag_s1 <= vin.world_copy;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) prod_s1[r][c] <= mat[r][c] * vext[c];
				// w of the vertex is 1.0: a plain shift
				prod_s1[r][3] <= PW'(mat[r][3]) <<< 16;
			end
		end
	end

	// ---------------- stage 2: row sums, floored to 16 fraction bits (Q34.16)
	logic signed [SW-1:0] sum [4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = SW'(prod_s1[r][0]) + SW'(prod_s1[r][1])
			       + SW'(prod_s1[r][2]) + SW'(prod_s1[r][3]);
		end
	end

	logic signed [NW-1:0] num_s2 [4];   // index 3 is w
	logic                 tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			tag_s2 <= tag_s1;
			for (int r = 0; r < 4; r++) num_s2[r] <= sum[r][SW-1:16];
		end
	end

	// ---------------- stage 3: signs, magnitudes, divider request
	hvt_pkg::div_t req;
	always_comb begin
		logic          wneg;
		logic [NW-1:0] mag;
		wneg       = num_s2[3][NW-1];
		req        = '0;
		req.d      = wneg ? NW'(-num_s2[3]) : NW'(num_s2[3]);
		req.w_zero = (num_s2[3] == '0);
		req.tag    = tag_s2;
		for (int l = 0; l < 3; l++) begin
			mag            = num_s2[l][NW-1] ? NW'(-num_s2[l]) : NW'(num_s2[l]);
			req.num_neg[l] = num_s2[l][NW-1];
			req.num_nz[l]  = (num_s2[l] != '0);
			req.neg[l]     = num_s2[l][NW-1] ^ wneg;
			req.r[l]       = RW'(mag) << 16;
		end
	end

	hvt_pkg::div_t req_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			req_s3 <= req;
		end
	end

	// ---------------- divider
	logic          div_out_valid, div_out_ready;
	hvt_pkg::div_t div_res;

	hvt_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_ready  (div_in_ready),
		.in_data   (req_s3),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.out_data  (div_res)
	);

	// ---------------- saturation, sign, status
	logic signed [CW-1:0] res [3];
	hvt_pkg::status_t     st;

	always_comb begin
		logic [QW-1:0] lim, qs;
		logic [2:0]    sat;
		for (int l = 0; l < 3; l++) begin
			lim    = div_res.neg[l] ? (QW'(1) << (CW-1)) : ((QW'(1) << (CW-1)) - QW'(1));
			sat[l] = div_res.q[l] > lim;
			qs     = sat[l] ? lim : div_res.q[l];
			if (div_res.w_zero) begin
				// w of zero: clip by the numerator's sign
				if (!div_res.num_nz[l])      res[l] = '0;
				else if (div_res.num_neg[l]) res[l] = {1'b1, {(CW-1){1'b0}}};
				else                         res[l] = {1'b0, {(CW-1){1'b1}}};
			end else begin
				res[l] = div_res.neg[l] ? CW'(-qs) : CW'(qs);
			end
		end
		if (div_res.w_zero)  st = hvt_pkg::ST_WZERO;
		else if (|sat)       st = hvt_pkg::ST_SAT;
		else                 st = hvt_pkg::ST_OK;
	end

	// ---------------- output register
	logic                    out_valid_q;
	logic signed [CW-1:0]    out_res_q [3];
	logic                    out_tag_q;
	hvt_pkg::status_t        out_st_q;

	assign div_out_ready = !out_valid_q || vout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_out_ready) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_ready) begin
			out_res_q <= res;
			out_tag_q <= div_res.tag;
			out_st_q  <= st;
		end
	end

	assign vout.valid          = out_valid_q;
	assign vout.out_x          = hvt_pkg::FW'(out_res_q[0]);
	assign vout.out_y          = hvt_pkg::FW'(out_res_q[1]);
	assign vout.out_z          = hvt_pkg::FW'(out_res_q[2]);
	assign vout.world_copy_out = out_tag_q;
	assign vout.status         = out_st_q;

endmodule

@@ rtl/hvt_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, three lanes.
module hvt_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hvt_pkg::div_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output hvt_pkg::div_t  out_data
);

	hvt_pkg::div_t data_s  [hvt_pkg::QW];
	logic          valid_s [hvt_pkg::QW];
	logic          adv     [hvt_pkg::QW+1];

	assign adv[hvt_pkg::QW] = out_ready;
	assign in_ready         = adv[0];
	assign out_valid        = valid_s[hvt_pkg::QW-1];
	assign out_data         = data_s[hvt_pkg::QW-1];

	for (genvar k = 0; k < hvt_pkg::QW; k++) begin : g_stage
		hvt_pkg::div_t src;
		logic          src_valid;
		if (k == 0) begin : g_first
			assign src       = in_data;
			assign src_valid = in_valid;
		end else begin : g_next
			assign src       = data_s[k-1];
			assign src_valid = valid_s[k-1];
		end

		assign adv[k] = !valid_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv[k]) begin
				valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				data_s[k] <= hvt_pkg::div_step(src, hvt_pkg::QBW'(hvt_pkg::QW-1-k));
			end
		end
	end

endmodule
